// ===== rtl/core/h2r_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package h2r_pkg;

  // hue units in one 60 degree sector (1/64 degree each)
  localparam int unsigned SECTOR_UNITS = 3840;
  // full scale of saturation, brightness and color channels
  localparam int unsigned FULL_SCALE   = 255;
  // highest sector index the hue field can produce (hue up to 32767)
  localparam int unsigned SECTOR_MAX   = 8;
  // reciprocal of 15 in 0.16 fixed point, rounded up so floor stays exact
  localparam int unsigned RECIP_15     = 4370;

  typedef struct packed {
    logic [14:0] hue;
    logic [7:0]  saturation;
    logic [7:0]  brightness;
  } hsv_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // 60 degree hue sectors; hue past 360 degrees folds into the last one
  typedef enum logic [2:0] {
    SECT_RED_YELLOW,
    SECT_YELLOW_GREEN,
    SECT_GREEN_CYAN,
    SECT_CYAN_BLUE,
    SECT_BLUE_MAGENTA,
    SECT_MAGENTA_RED
  } sector_t;

  // floor(y / 255), exact for y up to 65279
  function automatic logic [7:0] div255(input logic [15:0] y);
    logic [16:0] sum;
    sum = {1'b0, y} + 17'd1 + {9'd0, y[15:8]};
    return sum[15:8];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/hsv_to_rgb_converter_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake              Payload
// ------    ---------------------  ---------------------------------
// input     start && !busy         hsv : hue, saturation, brightness
// output    done per result        rgb : red, green, blue
//
// Five-stage pipeline: sector split, fraction products, divide by 3840,
// brightness products, divide by 255 and channel routing.
// One item per clock while busy is low; results leave in the order taken.
// Synchronous reset empties the pipeline; busy is high only around reset.
// The receiver cannot stall, so busy never rises in normal operation.

module hsv_to_rgb_converter_core
  import h2r_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  hsv_t hsv,
  output logic done,
  output rgb_t rgb
);

  logic accept;
  assign accept = start && !busy;

  // valid bits travel with the data
  logic valid1, valid2, valid3, valid4;

  // stage 1: sector and remainder within the sector
  sector_t     sector1;
  logic [11:0] rem1;
  logic [7:0]  sat1, bright1;

  // stage 2: saturation times fraction and its complement, p product
  sector_t     sector2;
  logic [19:0] sf_prod2, sfc_prod2;
  logic [15:0] p_prod2;
  logic [7:0]  bright2;
  logic        grey2;

  // stage 3: sf and sfc as n/255
  sector_t     sector3;
  logic [7:0]  sf3, sfc3;
  logic [15:0] p_prod3;
  logic [7:0]  bright3;
  logic        grey3;

  // stage 4: brightness products for q and t
  sector_t     sector4;
  logic [15:0] p_prod4, q_prod4, t_prod4;
  logic [7:0]  bright4;
  logic        grey4;

  // sector search over the fixed sector boundaries
  logic [3:0]  sector_idx;
  logic [14:0] sector_base;
  sector_t     sector_next;
  logic [11:0] rem_next;

  always_comb begin
    sector_idx  = '0;
    sector_base = '0;
    for (int k = 1; k <= int'(SECTOR_MAX); k++) begin
      if (hsv.hue >= 15'(k * SECTOR_UNITS)) begin
        sector_idx  = 4'(k);
        sector_base = 15'(k * SECTOR_UNITS);
      end
    end
    rem_next = 12'(hsv.hue - sector_base);
    if (sector_idx > 4'(SECT_MAGENTA_RED)) begin
      sector_next = SECT_MAGENTA_RED;
    end else begin
      sector_next = sector_t'(sector_idx[2:0]);
    end
  end

  // divide by 3840 as a shift by 8 and a reciprocal multiply by 15
  logic [24:0] sf_scaled, sfc_scaled;
  assign sf_scaled  = 25'(sf_prod2[19:8])  * 25'(RECIP_15);
  assign sfc_scaled = 25'(sfc_prod2[19:8]) * 25'(RECIP_15);

  // control: reset empties the pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b1;
      valid1 <= 1'b0;
      valid2 <= 1'b0;
      valid3 <= 1'b0;
      valid4 <= 1'b0;
      done   <= 1'b0;
    end else begin
      busy   <= 1'b0;
      valid1 <= accept;
      valid2 <= valid1;
      valid3 <= valid2;
      valid4 <= valid3;
      done   <= valid4;
    end
  end

  // datapath registers
  rgb_t rgb_next;

  always_ff @(posedge clk) begin
    // stage 1
    sector1 <= sector_next;
    rem1    <= rem_next;
    sat1    <= hsv.saturation;
    bright1 <= hsv.brightness;

    // stage 2
    sector2   <= sector1;
    sf_prod2  <= 20'(sat1) * 20'(rem1);
    sfc_prod2 <= 20'(sat1) * 20'(12'(SECTOR_UNITS) - rem1);
    p_prod2   <= 16'(bright1) * 16'(8'(FULL_SCALE) - sat1);
    bright2   <= bright1;
    grey2     <= (sat1 == 8'd0);

    // stage 3
    sector3 <= sector2;
    sf3     <= sf_scaled[23:16];
    sfc3    <= sfc_scaled[23:16];
    p_prod3 <= p_prod2;
    bright3 <= bright2;
    grey3   <= grey2;

    // stage 4
    sector4 <= sector3;
    p_prod4 <= p_prod3;
    q_prod4 <= 16'(bright3) * 16'(8'(FULL_SCALE) - sf3);
    t_prod4 <= 16'(bright3) * 16'(8'(FULL_SCALE) - sfc3);
    bright4 <= bright3;
    grey4   <= grey3;

    // stage 5
    rgb <= rgb_next;
  end

  // stage 5: scale back to n/255 and route
  h2r_route u_route (
    .sector (sector4),
    .grey   (grey4),
    .v      (bright4),
    .p      (div255(p_prod4)),
    .q      (div255(q_prod4)),
    .t      (div255(t_prod4)),
    .rgb    (rgb_next)
  );

`ifndef ASSERT_OFF
  // a result only follows a taken item
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, 5))
    else $error("result without a matching item");

  // every item taken yields a result
  a_no_loss: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##5 done)
    else $error("item lost in pipeline");

  // zero saturation gives grey at the item's brightness
  a_grey: assert property (@(posedge clk) disable iff (rst)
    (accept && hsv.saturation == 8'd0) |-> ##5
      (rgb.red == $past(hsv.brightness, 5) && rgb.green == rgb.red &&
       rgb.blue == rgb.red))
    else $error("grey pixel mismatch");

  // one channel carries the brightness and none exceeds it
  a_bright: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##5
      ((rgb.red == $past(hsv.brightness, 5) ||
        rgb.green == $past(hsv.brightness, 5) ||
        rgb.blue == $past(hsv.brightness, 5)) &&
       rgb.red <= $past(hsv.brightness, 5) &&
       rgb.green <= $past(hsv.brightness, 5) &&
       rgb.blue <= $past(hsv.brightness, 5)))
    else $error("channel does not match brightness");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/h2r_route.sv =====
`timescale 1ns / 1ps
`default_nettype none

module h2r_route
  import h2r_pkg::*;
(
  input  sector_t    sector,
  input  logic       grey,
  input  logic [7:0] v,
  input  logic [7:0] p,
  input  logic [7:0] q,
  input  logic [7:0] t,
  output rgb_t       rgb
);

  // route v, p, q, t onto the channels by sector; zero saturation is grey
  always_comb begin
    if (grey) begin
      rgb = '{red: v, green: v, blue: v};
    end else begin
      case (sector)
        SECT_RED_YELLOW:   rgb = '{red: v, green: t, blue: p};
        SECT_YELLOW_GREEN: rgb = '{red: q, green: v, blue: p};
        SECT_GREEN_CYAN:   rgb = '{red: p, green: v, blue: t};
        SECT_CYAN_BLUE:    rgb = '{red: p, green: q, blue: v};
        SECT_BLUE_MAGENTA: rgb = '{red: t, green: p, blue: v};
        default:           rgb = '{red: v, green: p, blue: q};
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import h2r_pkg::*;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  hsv_t hsv;
  logic done;
  rgb_t rgb;

  // pixels still owed by the pipeline, oldest first
  rgb_t pending_rgb[$];
  int mismatch_count;
  // when set, items go in back to back with no idle cycles
  bit back_to_back;

  hsv_to_rgb_converter_core u_dut (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .hsv  (hsv),
    .done (done),
    .rgb  (rgb)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Expected color for one HSV pixel: sector split, truncated products, routing
  function automatic rgb_t predict_rgb(input hsv_t px);
    int unsigned s;
    int unsigned v;
    int unsigned sec;
    int unsigned rem;
    int unsigned sf;
    int unsigned sfc;
    int unsigned p;
    int unsigned q;
    int unsigned t;
    sector_t zone;
    rgb_t c;
    s = px.saturation;
    v = px.brightness;
    if (s == 0) begin
      c.red   = 8'(v);
      c.green = 8'(v);
      c.blue  = 8'(v);
      return c;
    end
    sec = px.hue / SECTOR_UNITS;
    rem = px.hue % SECTOR_UNITS;
    sf  = (s * rem) / SECTOR_UNITS;
    sfc = (s * (SECTOR_UNITS - rem)) / SECTOR_UNITS;
    p   = (v * (FULL_SCALE - s)) / FULL_SCALE;
    q   = (v * (FULL_SCALE - sf)) / FULL_SCALE;
    t   = (v * (FULL_SCALE - sfc)) / FULL_SCALE;
    // hue past 360 degrees lands in sectors 6..8, routed like the last one
    zone = (sec >= 5) ? SECT_MAGENTA_RED : sector_t'(sec);
    case (zone)
      SECT_RED_YELLOW: begin
        c.red = 8'(v); c.green = 8'(t); c.blue = 8'(p);
      end
      SECT_YELLOW_GREEN: begin
        c.red = 8'(q); c.green = 8'(v); c.blue = 8'(p);
      end
      SECT_GREEN_CYAN: begin
        c.red = 8'(p); c.green = 8'(v); c.blue = 8'(t);
      end
      SECT_CYAN_BLUE: begin
        c.red = 8'(p); c.green = 8'(q); c.blue = 8'(v);
      end
      SECT_BLUE_MAGENTA: begin
        c.red = 8'(t); c.green = 8'(p); c.blue = 8'(v);
      end
      default: begin
        c.red = 8'(v); c.green = 8'(p); c.blue = 8'(q);
      end
    endcase
    return c;
  endfunction

  function automatic hsv_t make_hsv(input int unsigned h, input int unsigned s,
                                    input int unsigned v);
    hsv_t px;
    px.hue        = 15'(h);
    px.saturation = 8'(s);
    px.brightness = 8'(v);
    return px;
  endfunction

  // Drive one item from a falling edge; hold start until it is taken.
  // Returns at the next falling edge with start still high.
  task automatic send_pixel(input hsv_t px);
    int gap;
    gap = back_to_back ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    hsv   <= px;
    do @(posedge clk); while (busy);
    pending_rgb.push_back(predict_rgb(px));
    @(negedge clk);
  endtask

  // Stop sending and let the pipeline empty out
  task automatic wait_for_results();
    start <= 1'b0;
    while (pending_rgb.size() > 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // Check each result against the oldest expected pixel
  always @(posedge clk) begin
    rgb_t want;
    if (!rst && done) begin
      if (pending_rgb.size() == 0) begin
        $error("unexpected result: rgb=%h", rgb);
        mismatch_count++;
      end else begin
        want = pending_rgb.pop_front();
        if (rgb.red !== want.red) begin
          $error("red: expected %0d, got %0d", want.red, rgb.red);
          mismatch_count++;
        end
        if (rgb.green !== want.green) begin
          $error("green: expected %0d, got %0d", want.green, rgb.green);
          mismatch_count++;
        end
        if (rgb.blue !== want.blue) begin
          $error("blue: expected %0d, got %0d", want.blue, rgb.blue);
          mismatch_count++;
        end
      end
    end
  end

  // Zero saturation gives grey whatever the hue
  task automatic test_grey_pixels();
    send_pixel(make_hsv(0, 0, 255));
    send_pixel(make_hsv(32767, 0, 0));
    send_pixel(make_hsv(12345, 0, 170));
  endtask

  // One pixel in the middle of every sector, plus sector edges
  task automatic test_sector_routing();
    for (int k = 0; k < 6; k++) begin
      send_pixel(make_hsv(k * SECTOR_UNITS + 1920, 200, 230));
    end
    send_pixel(make_hsv(0, 255, 255));
    send_pixel(make_hsv(SECTOR_UNITS - 1, 255, 255));
    send_pixel(make_hsv(SECTOR_UNITS, 128, 255));
    send_pixel(make_hsv(23039, 255, 200));
  endtask

  // Hue at and past 360 degrees folds into the last sector
  task automatic test_hue_wrap();
    send_pixel(make_hsv(23040, 255, 255));
    send_pixel(make_hsv(27000, 100, 180));
    send_pixel(make_hsv(30720, 77, 255));
    send_pixel(make_hsv(32767, 255, 255));
  endtask

  // Extreme saturation and brightness
  task automatic test_channel_extremes();
    send_pixel(make_hsv(5000, 1, 255));
    send_pixel(make_hsv(9000, 255, 1));
    send_pixel(make_hsv(17000, 255, 0));
    send_pixel(make_hsv(21000, 254, 254));
  endtask

  // Random pixels, bursts with and without idle cycles, one full drain midway
  task automatic test_random_pixels(input int count);
    int unsigned h;
    int unsigned s;
    int unsigned v;
    for (int n = 0; n < count; n++) begin
      if (n % 64 == 0) back_to_back = ($urandom_range(0, 2) == 0);
      if (n == count / 2) wait_for_results();
      h = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 32767)
                                      : $urandom_range(0, 23039);
      case ($urandom_range(0, 15))
        0:       s = 0;
        1:       s = 255;
        default: s = $urandom_range(0, 255);
      endcase
      case ($urandom_range(0, 15))
        0:       v = 0;
        1:       v = 255;
        default: v = $urandom_range(0, 255);
      endcase
      send_pixel(make_hsv(h, s, v));
    end
    back_to_back = 1'b0;
  endtask

  initial begin
    rst            = 1'b1;
    start          = 1'b0;
    hsv            = '0;
    mismatch_count = 0;
    back_to_back   = 1'b0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_grey_pixels();
    test_sector_routing();
    test_hue_wrap();
    test_channel_extremes();
    wait_for_results();
    test_random_pixels(1000);
    wait_for_results();

    if (pending_rgb.size() != 0) begin
      $error("%0d results never arrived", pending_rgb.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
